FILE: rtl/core/ternary_template_window_matcher_macros.svh
// Assertion macros for the template window matcher.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef TERNARY_TEMPLATE_WINDOW_MATCHER_MACROS_SVH
`define TERNARY_TEMPLATE_WINDOW_MATCHER_MACROS_SVH
`ifndef ASSERT_OFF
`define TTWM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("ttwm assertion failed");
`define TTWM_ASSERT_NEXT(lbl, cond, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error("ttwm assertion failed");
`else
`define TTWM_ASSERT(lbl, prop)
`define TTWM_ASSERT_NEXT(lbl, cond, expr)
`endif
`endif

FILE: rtl/core/ttwm_pkg.sv
// Shared constants and types of the template window matcher.
// No dependencies.
package ttwm_pkg;

    localparam int DEF_MAX_IMAGE_WIDTH = 1024;
    localparam int DEF_MAX_TMPL_W      = 8;
    localparam int DEF_MAX_TMPL_H      = 8;
    localparam int DEF_NUM_SLOTS       = 4;
    localparam int MAX_IMAGE_HEIGHT    = 4096;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 13;
    localparam int PIX_W       = 32;
    localparam int ROW_W       = 12;
    localparam int HIT_COL_W   = 10;
    localparam int HIT_ROW_W   = 12;
    localparam int HIT_SLOT_W  = 2;
    localparam int HIT_NUM_W   = 20;
    localparam logic [HIT_NUM_W-1:0] HIT_MAX = 20'hFFFFF;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TMPL_WIDTH   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_TMPL_HEIGHT  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_REF_DX       = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_REF_DY       = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_NUM_TMPL     = 3'd6;

    // cell codes
    localparam logic [1:0] CODE_IGNORE = 2'd0;
    localparam logic [1:0] CODE_MATCH  = 2'd1;
    localparam logic [1:0] CODE_DIFFER = 2'd2;

    localparam logic [7:0] RED_IGNORE = 8'd255;
    localparam logic [7:0] RED_DIFFER = 8'd0;

    typedef struct packed {
        logic [HIT_NUM_W-1:0]  number;
        logic                  mirrored;
        logic [HIT_SLOT_W-1:0] slot;
        logic [HIT_ROW_W-1:0]  row;
        logic [HIT_COL_W-1:0]  col;
    } t_hit;

endpackage

FILE: rtl/core/ttwm_linebuf.sv
// Line buffers: one memory per stored image row, all read at one column.
// Depends on ttwm_pkg.
module ttwm_linebuf #(
    parameter int DEPTH = ttwm_pkg::DEF_MAX_IMAGE_WIDTH,
    parameter int ROWS  = ttwm_pkg::DEF_MAX_TMPL_H - 1,
    parameter int AW    = $clog2(DEPTH),
    parameter int RW    = (ROWS > 1) ? $clog2(ROWS) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [RW-1:0]               i_wrow,
    input  logic [AW-1:0]               i_addr,
    input  logic [ttwm_pkg::PIX_W-1:0]  i_wdata,
    input  logic                        i_re,
    output logic [ttwm_pkg::PIX_W-1:0]  o_q [ROWS]
);

    for (genvar g = 0; g < ROWS; g++) begin : g_row
        logic [ttwm_pkg::PIX_W-1:0] r_mem [DEPTH];
        logic [ttwm_pkg::PIX_W-1:0] r_q;

        // read returns the old word when the same address is written
        always_ff @(posedge i_clk) begin
            if (i_re) begin
                r_q <= r_mem[i_addr];
            end
            if (i_we && (i_wrow == RW'(g))) begin
                r_mem[i_addr] <= i_wdata;
            end
        end

        assign o_q[g] = r_q;
    end

endmodule

FILE: rtl/core/ternary_template_window_matcher.sv
// Channel   Dir  Handshake                  Payload
// s_axis    in   s_axis_tvalid/tready       tuser=action, tdata=pixel..red
// m_axis    out  m_axis_tvalid/tready       tdata=hit col..number
// cfg       in   i_cfg_we                   i_cfg_addr, i_cfg_data
//
// One request per cycle while s_axis_tready is high, loads and pixels alike. A hit
// passes line buffer read, window shift, cell compare, then template match into
// the FIFO before it shows on m_axis_tvalid.
// Results queue in an 8-entry output FIFO; input stalls only when FIFO plus
// in-flight requests would exceed it. Reset is synchronous; line buffers and
// the window are not cleared, templates reset to ignore.
// Depends on ttwm_pkg, ttwm_linebuf and the macros header.
`include "ternary_template_window_matcher_macros.svh"
module ternary_template_window_matcher #(
    parameter int MAX_IMAGE_WIDTH = ttwm_pkg::DEF_MAX_IMAGE_WIDTH,
    parameter int MAX_TMPL_W      = ttwm_pkg::DEF_MAX_TMPL_W,
    parameter int MAX_TMPL_H      = ttwm_pkg::DEF_MAX_TMPL_H,
    parameter int NUM_SLOTS       = ttwm_pkg::DEF_NUM_SLOTS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [31:0] pixel_rgba, [33:32] slot_sel, [36:34] cell_col,
    // [39:37] cell_row, [47:40] cell_red
    input  logic [ttwm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [0] action
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [9:0] hit_col, [21:10] hit_row, [23:22] hit_slot, [24] hit_mirrored,
    // [44:25] hit_number, [47:45] zero
    output logic [ttwm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                                i_cfg_we,
    input  logic [ttwm_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [ttwm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int CW        = $clog2(MAX_IMAGE_WIDTH);
    localparam int LINE_ROWS = MAX_TMPL_H - 1;
    localparam int RPW       = (LINE_ROWS > 1) ? $clog2(LINE_ROWS) : 1;
    localparam int XW        = $clog2(MAX_TMPL_W);
    localparam int YW        = $clog2(MAX_TMPL_H);
    localparam int TWW       = $clog2(MAX_TMPL_W + 1);
    localparam int THW       = $clog2(MAX_TMPL_H + 1);
    localparam int SW        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int FIFO_DEPTH = 8;
    localparam int FPW       = $clog2(FIFO_DEPTH);
    localparam int PW        = ttwm_pkg::PIX_W;

    // ---------------- configuration ----------------
    logic [10:0] r_img_w;
    logic [12:0] r_img_h;
    logic [3:0]  r_tw_cfg, r_th_cfg;
    logic [2:0]  r_rdx, r_rdy, r_ntpl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w  <= 11'd640;
            r_img_h  <= 13'd480;
            r_tw_cfg <= 4'd4;
            r_th_cfg <= 4'd5;
            r_rdx    <= 3'd2;
            r_rdy    <= 3'd1;
            r_ntpl   <= 3'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                ttwm_pkg::CFG_IMAGE_WIDTH:  r_img_w  <= i_cfg_data[10:0];
                ttwm_pkg::CFG_IMAGE_HEIGHT: r_img_h  <= i_cfg_data[12:0];
                ttwm_pkg::CFG_TMPL_WIDTH:   r_tw_cfg <= i_cfg_data[3:0];
                ttwm_pkg::CFG_TMPL_HEIGHT:  r_th_cfg <= i_cfg_data[3:0];
                ttwm_pkg::CFG_REF_DX:       r_rdx    <= i_cfg_data[2:0];
                ttwm_pkg::CFG_REF_DY:       r_rdy    <= i_cfg_data[2:0];
                ttwm_pkg::CFG_NUM_TMPL:     r_ntpl   <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // clamped working values
    logic [CW:0]    w;
    logic [12:0]    h;
    logic [TWW-1:0] tw, rx;
    logic [THW-1:0] th, ry;
    int             nt;

    always_comb begin
        if (r_img_w == '0)                        w = (CW+1)'(1);
        else if (int'(r_img_w) > MAX_IMAGE_WIDTH) w = (CW+1)'(MAX_IMAGE_WIDTH);
        else                                      w = (CW+1)'(r_img_w);
        if (r_img_h == '0)                                  h = 13'd1;
        else if (int'(r_img_h) > ttwm_pkg::MAX_IMAGE_HEIGHT) h = 13'(ttwm_pkg::MAX_IMAGE_HEIGHT);
        else                                                h = r_img_h;
        if (r_tw_cfg == '0)                   tw = TWW'(1);
        else if (int'(r_tw_cfg) > MAX_TMPL_W) tw = TWW'(MAX_TMPL_W);
        else                                  tw = TWW'(r_tw_cfg);
        if (r_th_cfg == '0)                   th = THW'(1);
        else if (int'(r_th_cfg) > MAX_TMPL_H) th = THW'(MAX_TMPL_H);
        else                                  th = THW'(r_th_cfg);
        rx = (int'(r_rdx) < int'(tw)) ? TWW'(r_rdx) : tw - TWW'(1);
        ry = (int'(r_rdy) < int'(th)) ? THW'(r_rdy) : th - THW'(1);
        nt = (int'(r_ntpl) < NUM_SLOTS) ? int'(r_ntpl) : NUM_SLOTS;
    end

    // ---------------- stage 0: accept, position ----------------
    localparam int ROW_W_L = ttwm_pkg::ROW_W;

    logic s_accept, s_pix;
    logic r_v1, r_v2, r_v3;
    logic [3:0] inflight;
    logic [FPW:0] r_fcnt;

    assign inflight      = 4'(r_v1) + 4'(r_v2) + 4'(r_v3);
    assign s_axis_tready = (4'(r_fcnt) + inflight) < 4'(FIFO_DEPTH);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign s_pix         = s_axis_tuser;

    logic [CW-1:0]  r_col;
    logic [ROW_W_L-1:0] r_row;
    logic [RPW-1:0] r_rp;

    logic [CW-1:0]  c_col, n_col;
    logic [12:0]    c_row13, n_row13;
    logic [RPW-1:0] c_rp, n_rp;
    logic [CW:0]    c_next;
    logic           pre_wrap, win0, clr0;

    function automatic logic [RPW-1:0] rp_inc(input logic [RPW-1:0] v);
        return (v == RPW'(LINE_ROWS - 1)) ? '0 : v + RPW'(1);
    endfunction

    always_comb begin
        c_col    = r_col;
        c_row13  = {1'b0, r_row};
        c_rp     = r_rp;
        pre_wrap = 1'b0;
        if ((CW+1)'(r_col) >= w) begin
            c_col   = '0;
            c_row13 = {1'b0, r_row} + 13'd1;
            c_rp    = rp_inc(r_rp);
        end
        if (c_row13 >= h) begin
            c_row13  = '0;
            c_rp     = '0;
            pre_wrap = 1'b1;
        end
        c_next  = (CW+1)'(c_col) + (CW+1)'(1);
        n_col   = c_next[CW-1:0];
        n_row13 = c_row13;
        n_rp    = c_rp;
        if (c_next >= w) begin
            n_col   = '0;
            n_row13 = c_row13 + 13'd1;
            n_rp    = rp_inc(c_rp);
            if (n_row13 >= h) begin
                n_row13 = '0;
                n_rp    = '0;
            end
        end
        win0 = (int'(c_next) >= int'(tw)) && (int'(c_row13) + 1 >= int'(th));
        clr0 = pre_wrap || (c_col == '0 && c_row13 == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_rp  <= '0;
        end else if (s_accept && s_pix) begin
            r_col <= n_col;
            r_row <= n_row13[ROW_W_L-1:0];
            r_rp  <= n_rp;
        end
    end

    // load decode
    logic [7:0] in_red;
    logic [1:0] code0;
    logic       lok0;
    assign in_red = s_axis_tdata[47:40];
    assign code0  = (in_red == ttwm_pkg::RED_IGNORE) ? ttwm_pkg::CODE_IGNORE :
                    (in_red == ttwm_pkg::RED_DIFFER) ? ttwm_pkg::CODE_DIFFER :
                    ttwm_pkg::CODE_MATCH;
    assign lok0   = (int'(s_axis_tdata[33:32]) < NUM_SLOTS) &&
                    (int'(s_axis_tdata[36:34]) < MAX_TMPL_W) &&
                    (int'(s_axis_tdata[39:37]) < MAX_TMPL_H);

    // line buffers
    logic [PW-1:0] lb_q [LINE_ROWS];

    ttwm_linebuf #(
        .DEPTH (MAX_IMAGE_WIDTH),
        .ROWS  (LINE_ROWS),
        .AW    (CW),
        .RW    (RPW)
    ) u_linebuf (
        .i_clk   (i_clk),
        .i_we    (s_accept && s_pix),
        .i_wrow  (c_rp),
        .i_addr  (c_col),
        .i_wdata (s_axis_tdata[PW-1:0]),
        .i_re    (s_accept && s_pix),
        .o_q     (lb_q)
    );

    // ---------------- pipeline registers ----------------
    logic r_ld1, r_ld2, r_ld3;
    logic r_lok1, r_lok2, r_lok3;
    logic [1:0] r_code1, r_code2, r_code3;
    logic [1:0] r_lslot1, r_lslot2, r_lslot3;
    logic [2:0] r_lcol1, r_lcol2, r_lcol3, r_lrow1, r_lrow2, r_lrow3;
    logic [CW-1:0] r_c1, r_c2, r_c3;
    logic [ROW_W_L-1:0] r_r1, r_r2, r_r3;
    logic r_win1, r_win2, r_win3, r_clr1, r_clr2, r_clr3;
    logic [PW-1:0] r_pix1;
    logic [RPW-1:0] r_rp1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= s_accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ld1    <= !s_pix;
        r_lok1   <= lok0;
        r_code1  <= code0;
        r_lslot1 <= s_axis_tdata[33:32];
        r_lcol1  <= s_axis_tdata[36:34];
        r_lrow1  <= s_axis_tdata[39:37];
        r_c1     <= c_col;
        r_r1     <= c_row13[ROW_W_L-1:0];
        r_win1   <= win0;
        r_clr1   <= clr0;
        r_pix1   <= s_axis_tdata[PW-1:0];
        r_rp1    <= c_rp;
        r_ld2 <= r_ld1;  r_lok2 <= r_lok1;  r_code2 <= r_code1;  r_lslot2 <= r_lslot1;
        r_lcol2 <= r_lcol1;  r_lrow2 <= r_lrow1;  r_c2 <= r_c1;  r_r2 <= r_r1;
        r_win2 <= r_win1;  r_clr2 <= r_clr1;
        r_ld3 <= r_ld2;  r_lok3 <= r_lok2;  r_code3 <= r_code2;  r_lslot3 <= r_lslot2;
        r_lcol3 <= r_lcol2;  r_lrow3 <= r_lrow2;  r_c3 <= r_c2;  r_r3 <= r_r2;
        r_win3 <= r_win2;  r_clr3 <= r_clr2;
    end

    // ---------------- stage 1: window shift ----------------
    logic [PW-1:0] r_win [MAX_TMPL_H][MAX_TMPL_W];
    logic [PW-1:0] lb_sel [MAX_TMPL_H];

    always_comb begin
        logic [RPW:0] t;
        lb_sel[0] = r_pix1;
        for (int u = 1; u < MAX_TMPL_H; u++) begin
            // row (r - u) mod LINE_ROWS
            t = (RPW+1)'(r_rp1) + (RPW+1)'(LINE_ROWS - u);
            if (t >= (RPW+1)'(LINE_ROWS)) begin
                t = t - (RPW+1)'(LINE_ROWS);
            end
            lb_sel[u] = lb_q[t[RPW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1 && !r_ld1) begin
            for (int u = 0; u < MAX_TMPL_H; u++) begin
                for (int a = 1; a < MAX_TMPL_W; a++) begin
                    r_win[u][a] <= r_win[u][a-1];
                end
                r_win[u][0] <= lb_sel[u];
            end
        end
    end

    // ---------------- stage 2: cell compare ----------------
    logic [PW-1:0] ref_px;
    logic [MAX_TMPL_H-1:0][MAX_TMPL_W-1:0] eq2, in2, r_eq3, r_in3;

    always_comb begin
        logic [THW-1:0] tu;
        logic [TWW-1:0] ta;
        tu = th - THW'(1) - ry;
        ta = tw - TWW'(1) - rx;
        ref_px = r_win[tu[YW-1:0]][ta[XW-1:0]];
        for (int yi = 0; yi < MAX_TMPL_H; yi++) begin
            for (int xi = 0; xi < MAX_TMPL_W; xi++) begin
                tu = THW'(int'(th) - 1 - yi);
                ta = TWW'(int'(tw) - 1 - xi);
                in2[yi][xi] = (yi < int'(th)) && (xi < int'(tw));
                eq2[yi][xi] = (r_win[tu[YW-1:0]][ta[XW-1:0]] == ref_px);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_eq3 <= eq2;
        r_in3 <= in2;
    end

    // ---------------- stage 3: template match ----------------
    logic [1:0] r_tpl [NUM_SLOTS][MAX_TMPL_H][MAX_TMPL_W];
    logic          found;
    logic [SW-1:0] fslot;
    logic          fmir;

    always_comb begin
        logic          ok;
        logic [1:0]    code;
        logic [TWW-1:0] mi;
        logic          eq;
        found = 1'b0;
        fslot = '0;
        fmir  = 1'b0;
        for (int s = 0; s < NUM_SLOTS; s++) begin
            for (int m = 0; m < 2; m++) begin
                ok = 1'b1;
                for (int yi = 0; yi < MAX_TMPL_H; yi++) begin
                    for (int xi = 0; xi < MAX_TMPL_W; xi++) begin
                        mi   = (m == 1) ? TWW'(int'(tw) - 1 - xi) : TWW'(xi);
                        code = r_tpl[s][yi][mi[XW-1:0]];
                        eq   = r_eq3[yi][xi];
                        if (r_in3[yi][xi] &&
                            ((code == ttwm_pkg::CODE_MATCH && !eq) ||
                             (code == ttwm_pkg::CODE_DIFFER && eq))) begin
                            ok = 1'b0;
                        end
                    end
                end
                if (!found && ok && s < nt) begin
                    found = 1'b1;
                    fslot = SW'(s);
                    fmir  = (m == 1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
                for (int yi = 0; yi < MAX_TMPL_H; yi++) begin
                    for (int xi = 0; xi < MAX_TMPL_W; xi++) begin
                        r_tpl[s][yi][xi] <= ttwm_pkg::CODE_IGNORE;
                    end
                end
            end
        end else if (r_v3 && r_ld3 && r_lok3) begin
            r_tpl[SW'(r_lslot3)][YW'(r_lrow3)][XW'(r_lcol3)] <= r_code3;
        end
    end

    logic [ttwm_pkg::HIT_NUM_W-1:0] r_hits, hit_base;
    logic push;
    ttwm_pkg::t_hit hit;

    assign push     = r_v3 && !r_ld3 && r_win3 && found;
    assign hit_base = r_clr3 ? '0 : r_hits;

    always_comb begin
        hit.col      = ttwm_pkg::HIT_COL_W'(int'(r_c3) + 1 - int'(tw));
        hit.row      = ttwm_pkg::HIT_ROW_W'(int'(r_r3) + 1 - int'(th));
        hit.slot     = ttwm_pkg::HIT_SLOT_W'(fslot);
        hit.mirrored = fmir;
        hit.number   = hit_base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits <= '0;
        end else if (r_v3 && !r_ld3) begin
            r_hits <= hit_base +
                      ttwm_pkg::HIT_NUM_W'(push && (hit_base != ttwm_pkg::HIT_MAX));
        end
    end

    // ---------------- output FIFO ----------------
    ttwm_pkg::t_hit r_fifo [FIFO_DEPTH];
    logic [FPW-1:0] r_fwp, r_frp;
    logic pop;

    assign m_axis_tvalid = (r_fcnt != '0);
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata  = ttwm_pkg::OUT_TDATA_W'(r_fifo[r_frp]);

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_fwp] <= hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwp  <= '0;
            r_frp  <= '0;
            r_fcnt <= '0;
        end else begin
            if (push) r_fwp <= r_fwp + FPW'(1);
            if (pop)  r_frp <= r_frp + FPW'(1);
            r_fcnt <= r_fcnt + (FPW+1)'(push) - (FPW+1)'(pop);
        end
    end

    // ---------------- assertions ----------------
    `TTWM_ASSERT(a_fifo_room, push |-> (r_fcnt < (FPW+1)'(FIFO_DEPTH)))
    `TTWM_ASSERT(a_credit, (4'(r_fcnt) + inflight) <= 4'(FIFO_DEPTH))
    `TTWM_ASSERT_NEXT(a_hit_count, push && !r_clr3 && (r_hits != ttwm_pkg::HIT_MAX), r_hits == $past(r_hits) + 1'b1)

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the ternary template window matcher.
// Drives template loads and pixel streams and compares hits with a local predictor.
// Depends on ttwm_pkg and the ternary_template_window_matcher top level.
`timescale 1ns / 100ps
module tb_top;

    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 12;
    localparam int LINE_ROWS    = ttwm_pkg::DEF_MAX_TMPL_H - 1;
    localparam int STIM_ROWS    = 25;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    // [31:0] pixel_rgba, [33:32] slot_sel, [36:34] cell_col, [39:37] cell_row,
    // [47:40] cell_red
    logic [ttwm_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    // [0] action
    logic                             s_axis_tuser = 1'b0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    // [9:0] hit_col, [21:10] hit_row, [23:22] hit_slot, [24] hit_mirrored,
    // [44:25] hit_number, [47:45] zero
    logic [ttwm_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                             i_cfg_we = 1'b0;
    logic [ttwm_pkg::CFG_ADDR_W-1:0]  i_cfg_addr = '0;
    logic [ttwm_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;

    ternary_template_window_matcher i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [ttwm_pkg::PIX_W-1:0] line_buf [LINE_ROWS][ttwm_pkg::DEF_MAX_IMAGE_WIDTH];
    // [rows up][age]
    logic [ttwm_pkg::PIX_W-1:0] win [ttwm_pkg::DEF_MAX_TMPL_H][ttwm_pkg::DEF_MAX_TMPL_W];
    logic [1:0] cells [ttwm_pkg::DEF_NUM_SLOTS][ttwm_pkg::DEF_MAX_TMPL_H][ttwm_pkg::DEF_MAX_TMPL_W];
    int unsigned      col_pos, row_pos, hit_cnt;
    int unsigned      img_w, img_h, t_w, t_h, rdx, rdy, n_tmpl;

    ttwm_pkg::t_hit hit_q [$];
    logic           use_typed = 1'b0;
    ttwm_pkg::t_hit typed_hit;
    int             errors = 0;
    int unsigned    cycles = 0;
    int unsigned    tx_idle = 0, rx_idle = 0;
    int unsigned    hold_req = 0;

    function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    task automatic match_pixel(input logic [ttwm_pkg::IN_TDATA_W-1:0] d);
        int unsigned w, h, tw, th, rx, ry, nt, c, r, tc;
        logic [ttwm_pkg::PIX_W-1:0] pix, refc, px;
        logic [1:0] code;
        bit ok, found;
        ttwm_pkg::t_hit hit;
        w  = clampu(img_w, 1, ttwm_pkg::DEF_MAX_IMAGE_WIDTH);
        h  = clampu(img_h, 1, ttwm_pkg::MAX_IMAGE_HEIGHT);
        tw = clampu(t_w, 1, ttwm_pkg::DEF_MAX_TMPL_W);
        th = clampu(t_h, 1, ttwm_pkg::DEF_MAX_TMPL_H);
        rx = rdx < tw ? rdx : tw - 1;
        ry = rdy < th ? rdy : th - 1;
        nt = n_tmpl < ttwm_pkg::DEF_NUM_SLOTS ? n_tmpl : ttwm_pkg::DEF_NUM_SLOTS;
        pix = d[ttwm_pkg::PIX_W-1:0];
        found = 1'b0;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h) begin
            row_pos = 0;
            hit_cnt = 0;
        end
        c = col_pos;
        r = row_pos;
        for (int v = 0; v < ttwm_pkg::DEF_MAX_TMPL_H; v++)
            for (int k = ttwm_pkg::DEF_MAX_TMPL_W - 1; k > 0; k--)
                win[v][k] = win[v][k-1];
        win[0][0] = pix;
        for (int v = 1; v < ttwm_pkg::DEF_MAX_TMPL_H; v++)
            win[v][0] = line_buf[(r + 4096 * LINE_ROWS - v) % LINE_ROWS][c];
        line_buf[r % LINE_ROWS][c] = pix;

        if (c + 1 >= tw && r + 1 >= th) begin
            refc = win[th-1-ry][tw-1-rx];
            for (int s = 0; s < nt && !found; s++) begin
                for (int m = 0; m < 2 && !found; m++) begin
                    ok = 1'b1;
                    for (int yi = 0; yi < th; yi++) begin
                        for (int xi = 0; xi < tw; xi++) begin
                            tc = m ? tw - 1 - xi : xi;
                            code = cells[s][yi][tc];
                            px = win[th-1-yi][tw-1-xi];
                            if (code == ttwm_pkg::CODE_MATCH && px != refc) ok = 1'b0;
                            if (code == ttwm_pkg::CODE_DIFFER && px == refc) ok = 1'b0;
                        end
                    end
                    if (ok) begin
                        hit.col      = ttwm_pkg::HIT_COL_W'(c + 1 - tw);
                        hit.row      = ttwm_pkg::HIT_ROW_W'(r + 1 - th);
                        hit.slot     = ttwm_pkg::HIT_SLOT_W'(s);
                        hit.mirrored = 1'(m);
                        hit.number   = ttwm_pkg::HIT_NUM_W'(hit_cnt);
                        if (hit_cnt < ttwm_pkg::HIT_MAX) hit_cnt++;
                        hit_q.insert(hit_q.size(), use_typed ? typed_hit : hit);
                        found = 1'b1;
                    end
                end
            end
        end
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) begin
                row_pos = 0;
                hit_cnt = 0;
            end
        end
    endtask

    task automatic apply_request(input logic act, input logic [ttwm_pkg::IN_TDATA_W-1:0] d);
        logic [7:0] red;
        if (act) begin
            match_pixel(d);
        end else begin
            red = d[47:40];
            cells[d[33:32]][d[39:37]][d[36:34]] =
                red == ttwm_pkg::RED_IGNORE ? ttwm_pkg::CODE_IGNORE :
                (red == ttwm_pkg::RED_DIFFER ? ttwm_pkg::CODE_DIFFER : ttwm_pkg::CODE_MATCH);
        end
    endtask

    always @(posedge i_clk) begin
        ttwm_pkg::t_hit got, want;
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("FAIL ternary_template_window_matcher");
            $finish;
        end
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    ttwm_pkg::CFG_IMAGE_WIDTH:  img_w  = i_cfg_data[10:0];
                    ttwm_pkg::CFG_IMAGE_HEIGHT: img_h  = i_cfg_data[12:0];
                    ttwm_pkg::CFG_TMPL_WIDTH:   t_w    = i_cfg_data[3:0];
                    ttwm_pkg::CFG_TMPL_HEIGHT:  t_h    = i_cfg_data[3:0];
                    ttwm_pkg::CFG_REF_DX:       rdx    = i_cfg_data[2:0];
                    ttwm_pkg::CFG_REF_DY:       rdy    = i_cfg_data[2:0];
                    ttwm_pkg::CFG_NUM_TMPL:     n_tmpl = i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) apply_request(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) begin
                got = ttwm_pkg::t_hit'(m_axis_tdata[44:0]);
                if (hit_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected hit col %0d row %0d slot %0d mir %0d num %0d",
                                 got.col, got.row, got.slot, got.mirrored, got.number);
                end else begin
                    want = hit_q.pop_front();
                    if (got.col != want.col || got.row != want.row || got.slot != want.slot
                        || got.mirrored != want.mirrored || got.number != want.number) begin
                        errors++;
                        if (errors <= 10)
                            $display("hit mismatch: exp %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                                     want.col, want.row, want.slot, want.mirrored, want.number,
                                     got.col, got.row, got.slot, got.mirrored, got.number);
                    end
                end
            end
        end
    end

    // receiver: random stalls plus an occasional long hold-off
    always @(negedge i_clk) begin
        int unsigned hold_left;
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= $urandom_range(99) >= rx_idle;
        end
    end

    task automatic send_request(input logic act, input logic [ttwm_pkg::IN_TDATA_W-1:0] d);
        while ($urandom_range(99) < tx_idle) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (hit_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // leaves the write enable high; the caller drops it after the last write
    task automatic write_reg(input logic [ttwm_pkg::CFG_ADDR_W-1:0] idx,
                             input int unsigned val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= ttwm_pkg::CFG_DATA_W'(val);
        @(negedge i_clk);
    endtask

    task automatic configure(input int unsigned w, h, tw, th, dx, dy, nt);
        wait_idle();
        write_reg(ttwm_pkg::CFG_IMAGE_WIDTH, w);
        write_reg(ttwm_pkg::CFG_IMAGE_HEIGHT, h);
        write_reg(ttwm_pkg::CFG_TMPL_WIDTH, tw);
        write_reg(ttwm_pkg::CFG_TMPL_HEIGHT, th);
        write_reg(ttwm_pkg::CFG_REF_DX, dx);
        write_reg(ttwm_pkg::CFG_REF_DY, dy);
        write_reg(ttwm_pkg::CFG_NUM_TMPL, nt);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_cell(input int unsigned s, col, row, input logic [7:0] red);
        send_request(1'b0, {red, 3'(row), 3'(col), 2'(s), 32'($urandom)});
    endtask

    // a few cells of one random slot, mostly ignore
    task automatic load_templates(input int unsigned ign_pct, input int unsigned n);
        int unsigned s;
        logic [7:0] red;
        s = $urandom_range(ttwm_pkg::DEF_NUM_SLOTS - 1);
        repeat (n) begin
            if ($urandom_range(99) < ign_pct) red = ttwm_pkg::RED_IGNORE;
            else if ($urandom_range(1)) red = ttwm_pkg::RED_DIFFER;
            else red = 8'($urandom_range(1, 254));
            load_cell(s, $urandom_range(7), $urandom_range(7), red);
        end
    endtask

    task automatic send_pixels(input int unsigned n);
        logic [ttwm_pkg::PIX_W-1:0] pal [3];
        foreach (pal[i]) pal[i] = $urandom;
        repeat (n)
            send_request(1'b1, {16'($urandom),
                ($urandom_range(9) == 0) ? 32'($urandom) : pal[$urandom_range(1)]});
    endtask

    typedef struct {
        logic                            act;
        logic [ttwm_pkg::IN_TDATA_W-1:0] d;
        bit                              typed;
        ttwm_pkg::t_hit                  hit;
    } t_stim_row;

    t_stim_row stim [STIM_ROWS];

    initial begin
        t_stim_row row;
        // reset-time templates are all ignore, so a 4x5 image equal to the
        // reset template size yields exactly one hit on its last pixel
        stim[0] = '{1'b0, {ttwm_pkg::RED_IGNORE, 3'd7, 3'd7, 2'd3, 32'hFFFF_FFFF}, 0, '0};
        stim[1] = '{1'b0, {ttwm_pkg::RED_DIFFER, 3'd0, 3'd0, 2'd2, 32'h0}, 0, '0};
        stim[2] = '{1'b0, {8'd1, 3'd5, 3'd2, 2'd1, 32'h0}, 0, '0};
        stim[3] = '{1'b0, {8'd254, 3'd2, 3'd5, 2'd3, 32'h0}, 0, '0};
        stim[4] = '{1'b0, {8'd128, 3'd7, 3'd0, 2'd2, 32'h0}, 0, '0};
        for (int i = 0; i < 19; i++)
            stim[5 + i] = '{1'b1, {16'h0, (i % 2) ? 32'hFFFF_FFFF : 32'h0000_0000}, 0, '0};
        stim[24] = '{1'b1, {16'h0, 32'h1234_5678}, 1, '0};

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        img_w = 640; img_h = 480; t_w = 4; t_h = 5; rdx = 2; rdy = 1; n_tmpl = 1;
        col_pos = 0; row_pos = 0; hit_cnt = 0;
        foreach (cells[s, r, c]) cells[s][r][c] = ttwm_pkg::CODE_IGNORE;

        write_reg(ttwm_pkg::CFG_IMAGE_WIDTH, 4);
        write_reg(ttwm_pkg::CFG_IMAGE_HEIGHT, 5);
        i_cfg_we <= 1'b0;
        foreach (stim[i]) begin
            row = stim[i];
            use_typed = row.typed;
            typed_hit = row.hit;
            send_request(row.act, row.d);
            use_typed = 1'b0;
        end

        // full 12x8 frame so every line buffer entry used later has been written
        configure(12, 8, 8, 8, 7, 7, 4);
        send_pixels(96);

        for (int mode = 0; mode < 3; mode++) begin
            tx_idle = mode == 0 ? 21 : (mode == 1 ? 88 : 0);
            rx_idle = mode == 0 ? 88 : (mode == 1 ? 21 : 0);
            for (int p = 0; p < 2; p++) begin
                // partial frames leave the position beyond the new size: wraps
                configure($urandom_range(1, 12), $urandom_range(1, 10), $urandom_range(0, 9),
                          $urandom_range(0, 9), $urandom_range(7), $urandom_range(7),
                          $urandom_range(3) == 0 ? 7 : $urandom_range(4));
                if (p == 0) load_templates(60, 12);
                else repeat (6) load_cell($urandom_range(3), $urandom_range(7),
                                          $urandom_range(7), 8'($urandom));
                send_pixels($urandom_range(25, 40));
            end
        end

        // widest image, height clamped up to 1, oversized template; slot 0 row 0 ignore
        configure(2047, 0, 15, 0, 7, 7, 7);
        for (int c = 0; c < ttwm_pkg::DEF_MAX_TMPL_W; c++)
            load_cell(0, c, 0, ttwm_pkg::RED_IGNORE);
        hold_req = 400;
        send_pixels(40);

        // tallest image, one column; first with no templates, then with four slots
        configure(1, 8191, 0, 8, 0, 3, 0);
        send_pixels(20);
        configure(1, 8191, 1, 8, 0, 3, 4);
        load_templates(80, 6);
        send_pixels(40);

        wait_idle();
        if (errors == 0)
            $display("PASS ternary_template_window_matcher");
        else
            $display("FAIL ternary_template_window_matcher");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/ttwm_pkg.sv
rtl/core/ttwm_linebuf.sv
rtl/core/ternary_template_window_matcher.sv
test/tb_top.sv
